FILE: rtl/core/dpsd_pkg.sv
// ----------------------------------------------------------------------------
// dpsd_pkg
// Shared types and constants for the drum pad strike detector: beat
// structs for both channels, register indexes and lane/buffer control.
// ----------------------------------------------------------------------------
package dpsd_pkg;

  // Fixed geometry of the pad scan
  localparam int PADS            = 4;
  localparam int SAMPLE_BITS     = 10;
  localparam int LEVEL_BITS      = 8;
  localparam int MAX_SENSITIVITY = 3;

  localparam int SENS_BITS  = 2;
  localparam int THR_BITS   = 8;
  localparam int PADS_BITS  = 3;
  localparam int CFG_DATA_W = 8;
  localparam int CFG_ADDR_W = 2;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_SENSITIVITY = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_THRESHOLD   = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_PADS_IN_USE = 2'd2;

  // Input beat: one converter scan
  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample_0;
    logic [SAMPLE_BITS-1:0] sample_1;
    logic [SAMPLE_BITS-1:0] sample_2;
    logic [SAMPLE_BITS-1:0] sample_3;
  } in_beat_t;

  // Result beat
  typedef struct packed {
    logic                  strike_0;
    logic                  strike_1;
    logic                  strike_2;
    logic                  strike_3;
    logic [LEVEL_BITS-1:0] velocity_0;
    logic [LEVEL_BITS-1:0] velocity_1;
    logic [LEVEL_BITS-1:0] velocity_2;
    logic [LEVEL_BITS-1:0] velocity_3;
  } out_beat_t;

  // Settings shared by every lane
  typedef struct packed {
    logic [SENS_BITS-1:0] shift;
    logic [THR_BITS-1:0]  threshold;
  } lane_cfg_t;

  // Occupancy of the output buffer
  typedef struct packed {
    logic out_full;
    logic skid_full;
  } buf_status_t;

endpackage

FILE: rtl/core/dpsd_lane.sv
// ----------------------------------------------------------------------------
// dpsd_lane
// One pad's detector: scales the sample, tracks the level with hysteresis
// and reports a strike with the peak level when the level falls away.
// ----------------------------------------------------------------------------
module dpsd_lane (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                fire,
  input  logic                                active,
  input  dpsd_pkg::lane_cfg_t                 cfg,
  input  logic [dpsd_pkg::SAMPLE_BITS-1:0]    sample,
  output logic                                strike,
  output logic [dpsd_pkg::LEVEL_BITS-1:0]     velocity
);

  logic [dpsd_pkg::LEVEL_BITS-1:0] level_r, level_nxt;
  logic                            rising_r, rising_nxt;
  logic [dpsd_pkg::LEVEL_BITS-1:0] peak_r, peak_nxt;

  logic [dpsd_pkg::LEVEL_BITS-1:0] lvl;
  logic [dpsd_pkg::LEVEL_BITS:0]   fall_sum;
  logic [dpsd_pkg::LEVEL_BITS-1:0] rise_diff;

  // Scaled level, low byte only
  assign lvl       = dpsd_pkg::LEVEL_BITS'(sample >> cfg.shift);
  assign fall_sum  = {1'b0, lvl} + {1'b0, cfg.threshold};
  // only used once lvl is above threshold, so no wrap
  assign rise_diff = lvl - cfg.threshold;

  // Level tracking
  always_comb begin
    level_nxt  = level_r;
    rising_nxt = rising_r;
    peak_nxt   = peak_r;
    strike     = 1'b0;
    if (active) begin
      if (lvl <= cfg.threshold) begin
        level_nxt = '0;
      end else if (fall_sum < {1'b0, level_r}) begin
        if (rising_r) begin
          strike   = 1'b1;
          peak_nxt = level_r;
        end else begin
          level_nxt = lvl;
        end
        rising_nxt = 1'b0;
      end else if (rise_diff > level_r) begin
        level_nxt  = lvl;
        rising_nxt = 1'b1;
      end
    end
  end

  assign velocity = peak_nxt;

  // State update on an accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r  <= '0;
      rising_r <= 1'b0;
      peak_r   <= '0;
    end else if (fire) begin
      level_r  <= level_nxt;
      rising_r <= rising_nxt;
      peak_r   <= peak_nxt;
    end
  end

endmodule

FILE: rtl/core/dpsd_merge.sv
// ----------------------------------------------------------------------------
// dpsd_merge
// Gathers the lane results into one result beat and holds it in a
// two-entry output buffer (output register plus skid register).
// ----------------------------------------------------------------------------
module dpsd_merge (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                push,
  input  logic [dpsd_pkg::PADS-1:0]           strike,
  input  logic [dpsd_pkg::LEVEL_BITS-1:0]     velocity [dpsd_pkg::PADS],
  output logic                                out_valid,
  input  logic                                out_ready,
  output dpsd_pkg::out_beat_t                 out_data,
  output dpsd_pkg::buf_status_t               status
);

  dpsd_pkg::out_beat_t beat;
  dpsd_pkg::out_beat_t out_r, skid_r;
  logic                out_valid_r, skid_valid_r;
  logic                pop;

  // Combine lane results
  always_comb begin
    beat            = '0;
    beat.strike_0   = strike[0];
    beat.strike_1   = strike[1];
    beat.strike_2   = strike[2];
    beat.strike_3   = strike[3];
    beat.velocity_0 = velocity[0];
    beat.velocity_1 = velocity[1];
    beat.velocity_2 = velocity[2];
    beat.velocity_3 = velocity[3];
  end

  assign pop = out_valid_r && out_ready;

  // Buffer control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (pop) begin
      if (skid_valid_r) begin
        skid_valid_r <= push;
      end else begin
        out_valid_r <= push;
      end
    end else if (!out_valid_r) begin
      out_valid_r <= push;
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  // Buffer payload
  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
        if (push) begin
          skid_r <= beat;
        end
      end else if (push) begin
        out_r <= beat;
      end
    end else if (!out_valid_r) begin
      if (push) begin
        out_r <= beat;
      end
    end else if (push) begin
      skid_r <= beat;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_data         = out_r;
  assign status.out_full  = out_valid_r;
  assign status.skid_full = skid_valid_r;

endmodule

FILE: rtl/core/drum_pad_strike_detector.sv
// ----------------------------------------------------------------------------
// drum_pad_strike_detector
// Piezo drum pad strike detector with four parallel pad lanes.
// ----------------------------------------------------------------------------
// Each input beat is one scan of four pad samples; each accepted beat gives
// exactly one result beat with a strike flag and the latched peak velocity
// per pad. All four lanes work on a scan at once and update their state in
// the cycle the beat is accepted, so one scan is taken every clock while
// the skid register is empty. A two-entry output buffer lets input keep
// flowing for one beat while the output is stalled. Registers: 0 sensitivity
// (shift right by 3 minus it), 1 threshold, 2 pads in use (pads from 0 up).
module drum_pad_strike_detector (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  dpsd_pkg::in_beat_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output dpsd_pkg::out_beat_t                 out_data,
  input  logic                                cfg_we,
  input  logic [dpsd_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [dpsd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  logic [dpsd_pkg::SENS_BITS-1:0]   sens_r;
  logic [dpsd_pkg::THR_BITS-1:0]    thr_r;
  logic [dpsd_pkg::PADS_BITS-1:0]   pads_r;

  dpsd_pkg::lane_cfg_t              lane_cfg;
  dpsd_pkg::buf_status_t            status;
  logic                             in_fire;
  logic [dpsd_pkg::SAMPLE_BITS-1:0] samples  [dpsd_pkg::PADS];
  logic [dpsd_pkg::PADS-1:0]        strike;
  logic [dpsd_pkg::LEVEL_BITS-1:0]  velocity [dpsd_pkg::PADS];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sens_r <= dpsd_pkg::SENS_BITS'(3);
      thr_r  <= dpsd_pkg::THR_BITS'(1);
      pads_r <= dpsd_pkg::PADS_BITS'(dpsd_pkg::PADS);
    end else if (cfg_we) begin
      case (cfg_addr)
        dpsd_pkg::REG_SENSITIVITY: sens_r <= cfg_wdata[dpsd_pkg::SENS_BITS-1:0];
        dpsd_pkg::REG_THRESHOLD:   thr_r  <= cfg_wdata[dpsd_pkg::THR_BITS-1:0];
        dpsd_pkg::REG_PADS_IN_USE: pads_r <= cfg_wdata[dpsd_pkg::PADS_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Gain shift, saturating at zero
  always_comb begin
    lane_cfg.threshold = thr_r;
    if (3'(sens_r) >= 3'(dpsd_pkg::MAX_SENSITIVITY)) begin
      lane_cfg.shift = '0;
    end else begin
      lane_cfg.shift = dpsd_pkg::SENS_BITS'(dpsd_pkg::MAX_SENSITIVITY) - sens_r;
    end
  end

  assign in_ready = !status.skid_full;
  assign in_fire  = in_valid && in_ready;

  assign samples[0] = in_data.sample_0;
  assign samples[1] = in_data.sample_1;
  assign samples[2] = in_data.sample_2;
  assign samples[3] = in_data.sample_3;

  // Pad lanes
  for (genvar i = 0; i < dpsd_pkg::PADS; i++) begin : g_lane
    dpsd_lane u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .fire     (in_fire),
      .active   (dpsd_pkg::PADS_BITS'(i) < pads_r),
      .cfg      (lane_cfg),
      .sample   (samples[i]),
      .strike   (strike[i]),
      .velocity (velocity[i])
    );
  end

  // Result merge and output buffer
  dpsd_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_fire),
    .strike    (strike),
    .velocity  (velocity),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .status    (status)
  );

  // Skid entry is only used behind a full output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    status.skid_full |-> status.out_full)
    else $error("skid register holds a beat while output register is empty");

  // Skid fills only when the output was stalled
  a_skid_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(status.skid_full) |-> $past(status.out_full && !out_ready))
    else $error("skid register filled without an output stall");

  // No pad in use means no strike
  a_no_pads_no_strike: assert property (@(posedge clk) disable iff (!rst_n)
    (pads_r == '0) |-> (strike == '0))
    else $error("strike reported with no pads in use");

endmodule

FILE: test/drum_pad_strike_detector_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drum_pad_strike_detector_test
// Self-checking bench for the four-pad strike detector. Directed scans hit
// the sample extremes and the rise, fall and strike paths. Random scans
// follow with per-pad hit envelopes plus noise, under several register
// settings and handshake idling patterns. A local pad-state model predicts
// every result beat and the monitor compares each field in order.
// ----------------------------------------------------------------------------
module drum_pad_strike_detector_test;
  import dpsd_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_beat_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_beat_t             out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Scans waiting to go out, and result beats still owed by the block
  in_beat_t  scans_to_send [$];
  out_beat_t results_due [$];

  // Register copies and per-pad state of the local model
  logic [SENS_BITS-1:0]  sens_cfg = 2'd3;
  logic [THR_BITS-1:0]   thr_cfg  = 8'd1;
  logic [PADS_BITS-1:0]  pads_cfg = 3'd4;
  logic [LEVEL_BITS-1:0] pad_level [PADS] = '{default: '0};
  logic                  pad_rising [PADS] = '{default: 1'b0};
  logic [LEVEL_BITS-1:0] pad_peak [PADS] = '{default: '0};

  // Stimulus envelope state per pad
  int env_stage [PADS] = '{default: 0};
  int env_peak [PADS] = '{default: 0};

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int errors = 0;

  drum_pad_strike_detector i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  // Advance the pad model by one scan and return the beat it should give
  function automatic out_beat_t predict_scan(in_beat_t scan);
    logic [SAMPLE_BITS-1:0] raw [PADS];
    logic                   hit [PADS];
    out_beat_t              res;
    int                     active;
    int                     shift;
    int                     lvl;
    int                     cur;
    int                     thr;
    raw[0] = scan.sample_0;
    raw[1] = scan.sample_1;
    raw[2] = scan.sample_2;
    raw[3] = scan.sample_3;
    active = (pads_cfg > PADS) ? PADS : int'(pads_cfg);
    shift = (sens_cfg >= MAX_SENSITIVITY) ? 0 : MAX_SENSITIVITY - int'(sens_cfg);
    thr = thr_cfg;
    for (int i = 0; i < PADS; i++) begin
      hit[i] = 1'b0;
      if (i < active) begin
        lvl = int'(raw[i] >> shift) & 255;
        cur = pad_level[i];
        if (lvl <= thr) begin
          pad_level[i] = '0;
        end else if (lvl + thr < cur) begin
          // falling: a strike only if the pad was on its way up
          if (pad_rising[i]) begin
            hit[i] = 1'b1;
            pad_peak[i] = cur[7:0];
          end else begin
            pad_level[i] = lvl[7:0];
          end
          pad_rising[i] = 1'b0;
        end else if (lvl - thr > cur) begin
          pad_level[i] = lvl[7:0];
          pad_rising[i] = 1'b1;
        end
      end
    end
    res.strike_0   = hit[0];
    res.strike_1   = hit[1];
    res.strike_2   = hit[2];
    res.strike_3   = hit[3];
    res.velocity_0 = pad_peak[0];
    res.velocity_1 = pad_peak[1];
    res.velocity_2 = pad_peak[2];
    res.velocity_3 = pad_peak[3];
    return res;
  endfunction

  // Driver: predict on each accepted beat, then present the next scan
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid)
        results_due.push_back(predict_scan(in_data));
      if (scans_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data  <= scans_to_send.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: check each result beat against the oldest prediction
  always @(posedge clk) begin
    out_beat_t want;
    logic [LEVEL_BITS-1:0] got_vel [PADS];
    logic [LEVEL_BITS-1:0] want_vel [PADS];
    logic got_hit [PADS];
    logic want_hit [PADS];
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          report_mismatch("unexpected result beat", 1, 0);
        end else begin
          want = results_due.pop_front();
          got_hit  = '{out_data.strike_0, out_data.strike_1,
                       out_data.strike_2, out_data.strike_3};
          want_hit = '{want.strike_0, want.strike_1, want.strike_2, want.strike_3};
          got_vel  = '{out_data.velocity_0, out_data.velocity_1,
                       out_data.velocity_2, out_data.velocity_3};
          want_vel = '{want.velocity_0, want.velocity_1,
                       want.velocity_2, want.velocity_3};
          for (int i = 0; i < PADS; i++) begin
            if (got_hit[i] !== want_hit[i])
              report_mismatch($sformatf("strike_%0d", i), got_hit[i], want_hit[i]);
            if (got_vel[i] !== want_vel[i])
              report_mismatch($sformatf("velocity_%0d", i), got_vel[i], want_vel[i]);
          end
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  function automatic in_beat_t scan4(int s0, int s1, int s2, int s3);
    in_beat_t s;
    s.sample_0 = s0[SAMPLE_BITS-1:0];
    s.sample_1 = s1[SAMPLE_BITS-1:0];
    s.sample_2 = s2[SAMPLE_BITS-1:0];
    s.sample_3 = s3[SAMPLE_BITS-1:0];
    return s;
  endfunction

  // Wait until the sender is empty and every owed beat has come back
  task automatic drain();
    while (scans_to_send.size() != 0 || in_valid || results_due.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    case (addr)
      REG_SENSITIVITY: sens_cfg = data[SENS_BITS-1:0];
      REG_THRESHOLD:   thr_cfg  = data[THR_BITS-1:0];
      REG_PADS_IN_USE: pads_cfg = data[PADS_BITS-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random scans: mostly per-pad hit envelopes (swell, peak, decay, quiet)
  // with jitter, some scans of pure noise
  task automatic queue_hits(int count);
    int smp [PADS];
    int stage_now;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < 15) begin
        scans_to_send.push_back(in_beat_t'($urandom));
        continue;
      end
      for (int p = 0; p < PADS; p++) begin
        stage_now = env_stage[p];
        case (env_stage[p])
          0: begin
            smp[p] = $urandom_range(0, 15);
            if ($urandom_range(0, 99) < 40) begin
              env_peak[p]  = $urandom_range(0, 1023);
              env_stage[p] = 1;
            end
          end
          1: smp[p] = env_peak[p] / 3;
          2: smp[p] = env_peak[p];
          3: smp[p] = env_peak[p] / 4;
          default: smp[p] = $urandom_range(0, 31);
        endcase
        // a freshly started envelope begins with its swell on the next scan
        if (stage_now != 0)
          env_stage[p] = (stage_now >= 4) ? 0 : stage_now + 1;
        smp[p] = smp[p] + $urandom_range(0, 7);
        if (smp[p] > 1023)
          smp[p] = 1023;
      end
      scans_to_send.push_back(scan4(smp[0], smp[1], smp[2], smp[3]));
    end
  endtask

  // One random phase under fixed settings, with a full pause halfway
  task automatic run_phase(int sens, int thr, int pads, int count);
    drain();
    write_reg(REG_SENSITIVITY, {6'($urandom), sens[1:0]});
    write_reg(REG_THRESHOLD, thr[7:0]);
    write_reg(REG_PADS_IN_USE, {5'($urandom), pads[2:0]});
    queue_hits(count / 2);
    drain();
    queue_hits(count - count / 2);
  endtask

  // Sequence: reset, directed scans, random phases, final drain
  initial begin
    send_idle_pct = 33;
    recv_idle_pct = 59;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: no shift, threshold 1, all pads active
    scans_to_send.push_back(scan4(0, 0, 0, 0));
    scans_to_send.push_back(scan4(1023, 1023, 1023, 1023));  // level wraps to 255
    scans_to_send.push_back(scan4(512, 256, 768, 1));        // low byte zero: clears
    scans_to_send.push_back(scan4(200, 200, 200, 200));      // rise
    scans_to_send.push_back(scan4(100, 198, 199, 197));      // strike on pads 0, 1 and 3
    scans_to_send.push_back(scan4(50, 150, 201, 196));       // fall without rise
    scans_to_send.push_back(scan4(150, 10, 202, 2));
    scans_to_send.push_back(scan4(150, 1, 203, 1));          // at threshold: clears
    scans_to_send.push_back(scan4(149, 2, 10, 255));
    scans_to_send.push_back(scan4(10, 3, 9, 0));             // strike on pad 0
    scans_to_send.push_back(scan4(300, 255, 0, 128));
    scans_to_send.push_back(scan4(20, 40, 0, 30));
    scans_to_send.push_back(scan4(1023, 0, 1023, 0));
    scans_to_send.push_back(scan4(0, 1023, 0, 1023));
    drain();

    // Write to the unused index: must change nothing
    write_reg(REG_UNUSED, 8'($urandom));
    scans_to_send.push_back(scan4(255, 255, 255, 255));
    scans_to_send.push_back(scan4(2, 2, 2, 2));

    run_phase(0, 0, 4, 110);
    run_phase(1, 2, 2, 100);
    run_phase(2, 255, 4, 60);

    send_idle_pct = 59;
    recv_idle_pct = 33;
    run_phase(3, 5, 0, 60);
    run_phase(0, 3, 7, 110);
    run_phase(2, 20, 1, 100);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase(1, $urandom_range(0, 40), 5, 110);
    run_phase(3, 1, 3, 110);

    drain();
    repeat (10) @(posedge clk);
    if (errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  // Watchdog
  initial begin
    #2ms;
    $display("Verification failed");
    $finish;
  end

endmodule
